>>> rtl/mdpr_pkg.sv
// Shared types and constants for the min distance point recorder.
`timescale 1ns / 1ps
`default_nettype none
package mdpr_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int JOINT_W        = 16;
    localparam int MAG_W          = 16;
    localparam int SQ_W           = 2 * MAG_W;
    localparam int DIST_W         = 34;
    localparam int STORED_W       = 9;
    localparam int DRAIN_CYCLES   = 3;
    localparam int DRAIN_W        = $clog2(DRAIN_CYCLES);

    localparam logic [DIST_W-1:0] THRESH_RESET = DIST_W'(167772);

    typedef logic signed [JOINT_W-1:0] t_joint;
    typedef logic [DIST_W-1:0]         t_dist;

    typedef struct packed {
        t_joint joint_d;
        t_joint joint_c;
        t_joint joint_b;
        t_joint joint_a;
    } t_point;

    typedef struct packed {
        logic clear;
        logic en;
    } t_dist_ctl;

    typedef struct packed {
        logic  found;
        t_dist best;
    } t_dist_res;

endpackage
`default_nettype wire

>>> rtl/mdpr_in_if.sv
// Input channel carrying one four-joint sample word.
`timescale 1ns / 1ps
`default_nettype none
interface mdpr_in_if;
    import mdpr_pkg::*;

    logic   valid;
    logic   ready;
    t_joint joint_a;
    t_joint joint_b;
    t_joint joint_c;
    t_joint joint_d;

    modport source (output valid, output joint_a, output joint_b, output joint_c,
                    output joint_d, input ready);
    modport sink (input valid, input joint_a, input joint_b, input joint_c,
                  input joint_d, output ready);
endinterface
`default_nettype wire

>>> rtl/mdpr_out_if.sv
// Output channel carrying one decision word.
`timescale 1ns / 1ps
`default_nettype none
interface mdpr_out_if;
    import mdpr_pkg::*;

    logic                valid;
    logic                ready;
    logic                accepted;
    logic                table_full;
    logic [STORED_W-1:0] stored_points;

    modport source (output valid, output accepted, output table_full,
                    output stored_points, input ready);
    modport sink (input valid, input accepted, input table_full,
                  input stored_points, output ready);
endinterface
`default_nettype wire

>>> rtl/mdpr_cfg_if.sv
// Configuration write channel for the squared distance threshold.
`timescale 1ns / 1ps
`default_nettype none
interface mdpr_cfg_if;
    import mdpr_pkg::*;

    logic  valid;
    logic  ready;
    t_dist data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/mdpr_cell.sv
// One ring cell holding a stored point and its valid flag.
`timescale 1ns / 1ps
`default_nettype none
module mdpr_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_shift,
    input  wire mdpr_pkg::t_point i_point,
    input  wire logic            i_valid,
    output mdpr_pkg::t_point     o_point,
    output logic                 o_valid
);
    import mdpr_pkg::*;

    t_point r_point;
    logic   r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_point <= i_point;
        end
    end

    assign o_point = r_point;
    assign o_valid = r_valid;
endmodule
`default_nettype wire

>>> rtl/mdpr_dist.sv
// Squared distance pipeline and running minimum over the ring head.
`timescale 1ns / 1ps
`default_nettype none
module mdpr_dist (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mdpr_pkg::t_dist_ctl i_ctl,
    input  wire mdpr_pkg::t_point    i_sample,
    input  wire mdpr_pkg::t_point    i_point,
    output mdpr_pkg::t_dist_res      o_res
);
    import mdpr_pkg::*;

    logic                   r_v1;
    logic                   r_v2;
    logic                   r_v3;
    logic [3:0][MAG_W-1:0]  r_mag;
    logic [3:0][SQ_W-1:0]   r_sq;
    t_dist                  r_sum;
    logic                   r_found;
    t_dist                  r_best;

    t_joint [3:0]           w_s;
    t_joint [3:0]           w_p;
    logic [3:0][MAG_W-1:0]  n_mag;
    logic signed [JOINT_W:0] w_diff [4];
    logic [JOINT_W:0]       w_abs [4];
    t_dist                  n_sum;

    assign w_s = {i_sample.joint_d, i_sample.joint_c, i_sample.joint_b, i_sample.joint_a};
    assign w_p = {i_point.joint_d, i_point.joint_c, i_point.joint_b, i_point.joint_a};

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_diff[j] = {w_s[j][JOINT_W-1], w_s[j]} - {w_p[j][JOINT_W-1], w_p[j]};
            w_abs[j]  = w_diff[j][JOINT_W] ? (~w_diff[j] + 1'b1) : w_diff[j];
            n_mag[j]  = w_abs[j][MAG_W-1:0];
        end
    end

    assign n_sum = (DIST_W'(r_sq[0]) + DIST_W'(r_sq[1]))
                 + (DIST_W'(r_sq[2]) + DIST_W'(r_sq[3]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_v1 <= i_ctl.en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_ctl.clear) begin
                r_found <= 1'b0;
            end else if (r_v3) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        for (int j = 0; j < 4; j++) begin
            r_sq[j] <= r_mag[j] * r_mag[j];
        end
        r_sum <= n_sum;
        if (r_v3 && !i_ctl.clear && (!r_found || r_sum < r_best)) begin
            r_best <= r_sum;
        end
    end

    assign o_res.found = r_found;
    assign o_res.best  = r_best;
endmodule
`default_nettype wire

>>> rtl/min_distance_point_recorder.sv
// Top level: novelty filter that records joint samples far from all stored points.
`timescale 1ns / 1ps
`default_nettype none
// Each input word is a four-joint sample. The stored points sit in a ring of
// MAX_POINTS cells that rotates once per sample, the head cell feeding a
// three-stage squared distance pipeline with a running minimum. After a sample
// is accepted, the next is accepted only after a full ring rotation, the
// pipeline drain and the decision. The result word waits in an output
// register; a new sample is accepted while it waits, and the decision cycle
// holds only if the previous result is still not taken. A sample is stored
// when the table is empty or its least squared distance is strictly greater
// than the threshold; a far sample meeting a full table is flagged and dropped.
// stored_points is the count after the sample, modulo 512. The threshold is
// written through the config channel, which is always ready, and resets to
// 167772 (0.1 rad squared in Q.24).
module min_distance_point_recorder #(
    parameter int MAX_POINTS = mdpr_pkg::MAX_POINTS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    mdpr_in_if.sink      i_in,
    mdpr_cfg_if.sink     i_cfg,
    mdpr_out_if.source   o_out
);
    import mdpr_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int EXT_W = (CNT_W > STORED_W) ? CNT_W : STORED_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_scan;
    logic [DRAIN_W-1:0]  r_drain;
    logic [CNT_W-1:0]    r_cnt;
    t_dist               r_thresh;
    t_point              r_sample;
    logic                r_o_valid;
    logic                r_acc;
    logic                r_full;
    logic [STORED_W-1:0] r_stored;

    t_point              w_point [MAX_POINTS];
    logic                w_valid [MAX_POINTS];
    t_point              w_head_in;
    logic                w_head_valid;
    logic                w_shift;
    logic                w_in_fire;
    logic                w_go;
    logic                w_far;
    logic                w_room;
    logic                w_acc;
    logic [CNT_W-1:0]    n_cnt;
    logic [EXT_W-1:0]    w_cnt_ext;
    t_dist_ctl           w_ctl;
    t_dist_res           w_res;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_fire   = i_in.valid && i_in.ready;

    assign w_far  = !w_res.found || (w_res.best > r_thresh);
    assign w_room = (r_cnt != CNT_W'(MAX_POINTS));
    assign w_acc  = w_far && w_room;
    assign w_go   = (r_state == ST_FINISH) && (!r_o_valid || o_out.ready);
    assign n_cnt  = w_acc ? (r_cnt + 1'b1) : r_cnt;
    assign w_cnt_ext = EXT_W'(n_cnt);

    assign w_shift      = (r_state == ST_SCAN) || (w_go && w_acc);
    assign w_head_in    = (r_state == ST_SCAN) ? w_point[MAX_POINTS-1] : r_sample;
    assign w_head_valid = (r_state == ST_SCAN) ? w_valid[MAX_POINTS-1] : 1'b1;

    assign w_ctl.clear = w_in_fire;
    assign w_ctl.en    = (r_state == ST_SCAN) && w_valid[MAX_POINTS-1];

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_ring
        if (g == 0) begin : g_first
            mdpr_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_point (w_head_in),
                .i_valid (w_head_valid),
                .o_point (w_point[g]),
                .o_valid (w_valid[g])
            );
        end else begin : g_rest
            mdpr_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_point (w_point[g-1]),
                .i_valid (w_valid[g-1]),
                .o_point (w_point[g]),
                .o_valid (w_valid[g])
            );
        end
    end

    mdpr_dist u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (r_sample),
        .i_point  (w_point[MAX_POINTS-1]),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_scan    <= '0;
            r_drain   <= '0;
            r_cnt     <= '0;
            r_thresh  <= THRESH_RESET;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_thresh <= i_cfg.data;
            end
            if (w_go) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_fire) begin
                        r_sample.joint_a <= i_in.joint_a;
                        r_sample.joint_b <= i_in.joint_b;
                        r_sample.joint_c <= i_in.joint_c;
                        r_sample.joint_d <= i_in.joint_d;
                        r_scan           <= '0;
                        r_state          <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_scan <= r_scan + 1'b1;
                    if (r_scan == CNT_W'(MAX_POINTS - 1)) begin
                        r_drain <= '0;
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_drain <= r_drain + 1'b1;
                    if (r_drain == DRAIN_W'(DRAIN_CYCLES - 1)) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (w_go) begin
                        r_cnt     <= n_cnt;
                        r_acc     <= w_acc;
                        r_full    <= w_far && !w_room;
                        r_stored  <= w_cnt_ext[STORED_W-1:0];
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.accepted      = r_acc;
    assign o_out.table_full    = r_full;
    assign o_out.stored_points = r_stored;
endmodule
`default_nettype wire
